[design/wrhp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_pkg
// Shared types, codes and constants of the WAV/RIFF header parser.
// ----------------------------------------------------------------------------
package wrhp_pkg;

  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;  // "fmt "
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;  // "data"
  localparam logic [31:0] FMT_CORE = 32'd16;
  localparam logic [31:0] HDR_LEN  = 32'd12;
  localparam logic [31:0] CHK_LEN  = 32'd8;
  localparam logic [15:0] PCM_TAG  = 16'd1;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_CHUNK  = 6'b000010,
    PH_FMT    = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_HDR = 3'd1,
    ST_NO_FMT  = 3'd2,
    ST_NO_DATA = 3'd3,
    ST_NOT_PCM = 3'd4,
    ST_SHORT   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_valid;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_last;
    logic        report_valid;
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } result_t;

  // Expected header bytes: "RIFF", size (not checked), "WAVE".
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h52;
      4'd1:    b = 8'h49;
      4'd2:    b = 8'h46;
      4'd3:    b = 8'h46;
      4'd8:    b = 8'h57;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h56;
      4'd11:   b = 8'h45;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[design/wav_riff_header_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_header_parser_unit
// Streaming RIFF/WAVE parser: checks the header, walks the chunks, captures
// the fmt fields, forwards the data chunk body and gives one final report.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle, unless an item with a result waits for a
// full result register, from an input register through one level of parse
// logic into a result register. Each item yields at most one result: a
// data body byte, the report, or both on the final data byte. Items that
// yield nothing (header, chunk headers, fmt and skipped bytes) never wait on
// the output side. On a report with a nonzero status the format fields and
// data_size are zero and the payload already sent must be discarded. After
// the report, bytes are dropped until the end-of-file mark, which also
// returns the parser to its start state for the next file.
module wav_riff_header_parser_unit
  import wrhp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic [0:0]   in_tuser,   // [0] byte_valid
  input  logic         in_tlast,   // end_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] format_tag,
  // [42:27] channel_count, [74:43] rate_hz, [90:75] bits_per_sample,
  // [122:91] data_size, [127:123] zero
  output logic [127:0] out_tdata,
  output logic [1:0]   out_tuser,  // [0] payload_valid, [1] report_valid
  output logic         out_tlast   // payload_last
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_take;
  logic    slot_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.in_byte     = in_tdata;
  assign in_item.byte_valid  = in_tuser[0];
  assign in_item.end_of_file = in_tlast;

  wrhp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  wrhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  wrhp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'b0, out_res.data_size, out_res.bits_per_sample,
                      out_res.rate_hz, out_res.channel_count,
                      out_res.format_tag, out_res.status, out_res.payload_byte};
  assign out_tuser = {out_res.report_valid, out_res.payload_valid};
  assign out_tlast = out_res.payload_last;

  // final data byte always carries the report
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0] && out_tuser[1])
    else $error("payload_last without payload and report");

  // every result carries a payload byte or a report
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'b00)
    else $error("empty result item");

  // error report has zeroed format fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] && out_tdata[10:8] != ST_OK |-> out_tdata[122:11] == '0)
    else $error("error report with nonzero fields");

  // a held input item is not overwritten before the parser takes it
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s1_take |=> s1_valid && $stable(s1_item))
    else $error("input register lost an item");

endmodule

[design/wrhp_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_in_reg
// Input register: holds one accepted item until the parser takes it.
// ----------------------------------------------------------------------------
module wrhp_in_reg
  import wrhp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  s1_valid,
  output item_t s1_item,
  input  logic  s1_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (s1_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[design/wrhp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_parser
// Parse state and per-byte next-state logic: header check, chunk walk,
// fmt field capture, data pass-through and final report.
// ----------------------------------------------------------------------------
module wrhp_parser
  import wrhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_valid,
  input  item_t   s1_item,
  output logic    s1_take,
  input  logic    slot_free,
  output logic    res_valid,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic        good_r, good_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] ftag_r, ftag_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;

  logic [31:0] cnt_inc;
  logic [7:0]  b;
  logic        rep;
  status_t     rep_status;
  status_t     data_status;
  logic        emit;
  result_t     r;

  assign cnt_inc = cnt_r + 32'd1;
  assign b       = s1_item.in_byte;

  always_comb begin
    if (!fmt_seen_r) begin
      data_status = ST_NO_FMT;
    end else if (ftag_r != PCM_TAG) begin
      data_status = ST_NOT_PCM;
    end else begin
      data_status = ST_OK;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    good_nxt     = good_r;
    fmt_seen_nxt = fmt_seen_r;
    ftag_nxt     = ftag_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    rep          = 1'b0;
    rep_status   = ST_OK;
    r            = '0;

    if (s1_item.byte_valid) begin
      unique case (phase_r)
        PH_HEADER: begin
          if ((cnt_r[3:0] < 4'd4 || cnt_r[3:0] >= 4'd8) && b != hdr_byte(cnt_r[3:0])) begin
            good_nxt = 1'b0;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= HDR_LEN) begin
            cnt_nxt = '0;
            if (!good_nxt) begin
              rep        = 1'b1;
              rep_status = ST_BAD_HDR;
            end else begin
              phase_nxt = PH_CHUNK;
            end
          end
        end
        PH_CHUNK: begin
          if (cnt_r < 32'd4) begin
            tag_nxt = {tag_r[23:0], b};
          end else begin
            case (cnt_r[1:0])
              2'd0:    len_nxt[7:0]   = b;
              2'd1:    len_nxt[15:8]  = b;
              2'd2:    len_nxt[23:16] = b;
              default: len_nxt[31:24] = b;
            endcase
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CHK_LEN) begin
            cnt_nxt = '0;
            if (tag_nxt == TAG_FMT) begin
              fmt_seen_nxt = 1'b1;
              ftag_nxt     = '0;
              chan_nxt     = '0;
              rate_nxt     = '0;
              bits_nxt     = '0;
              phase_nxt    = PH_FMT;
            end else if (tag_nxt == TAG_DATA) begin
              if (len_nxt == '0) begin
                rep        = 1'b1;
                rep_status = data_status;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else if (len_nxt == '0) begin
              tag_nxt = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (cnt_r[31:4] == '0) begin
            case (cnt_r[3:0])
              4'd0:    ftag_nxt[7:0]   = b;
              4'd1:    ftag_nxt[15:8]  = b;
              4'd2:    chan_nxt[7:0]   = b;
              4'd3:    chan_nxt[15:8]  = b;
              4'd4:    rate_nxt[7:0]   = b;
              4'd5:    rate_nxt[15:8]  = b;
              4'd6:    rate_nxt[23:16] = b;
              4'd7:    rate_nxt[31:24] = b;
              4'd14:   bits_nxt[7:0]   = b;
              4'd15:   bits_nxt[15:8]  = b;
              default: ;
            endcase
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= FMT_CORE && cnt_inc >= len_r) begin
            cnt_nxt   = '0;
            tag_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_CHUNK;
          end
        end
        PH_SKIP: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            cnt_nxt   = '0;
            tag_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_CHUNK;
          end
        end
        PH_DATA: begin
          r.payload_byte  = b;
          r.payload_valid = 1'b1;
          cnt_nxt         = cnt_inc;
          if (cnt_inc >= len_r) begin
            r.payload_last = 1'b1;
            rep            = 1'b1;
            rep_status     = data_status;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    if (rep) begin
      phase_nxt = PH_DONE;
    end

    // end mark: report if none yet, then back to reset state
    if (s1_item.end_of_file) begin
      if (phase_nxt != PH_DONE) begin
        rep = 1'b1;
        if (phase_nxt == PH_HEADER) begin
          rep_status = ST_BAD_HDR;
        end else if (phase_nxt == PH_DATA) begin
          rep_status = ST_SHORT;
        end else if (!fmt_seen_nxt) begin
          rep_status = ST_NO_FMT;
        end else begin
          rep_status = ST_NO_DATA;
        end
      end
      phase_nxt    = PH_HEADER;
      cnt_nxt      = '0;
      tag_nxt      = '0;
      len_nxt      = '0;
      good_nxt     = 1'b1;
      fmt_seen_nxt = 1'b0;
      ftag_nxt     = '0;
      chan_nxt     = '0;
      rate_nxt     = '0;
      bits_nxt     = '0;
    end

    if (rep) begin
      r.report_valid = 1'b1;
      r.status       = rep_status;
      if (rep_status == ST_OK) begin
        r.format_tag      = ftag_r;
        r.channel_count   = chan_r;
        r.rate_hz         = rate_r;
        r.bits_per_sample = bits_r;
        r.data_size       = len_r;
      end
    end
  end

  assign emit      = rep || r.payload_valid;
  assign s1_take   = s1_valid && (!emit || slot_free);
  assign res_valid = s1_take && emit;
  assign res       = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_r      <= '0;
      tag_r      <= '0;
      len_r      <= '0;
      good_r     <= 1'b1;
      fmt_seen_r <= 1'b0;
      ftag_r     <= '0;
      chan_r     <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
    end else if (s1_take) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      good_r     <= good_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      ftag_r     <= ftag_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
    end
  end

endmodule

[design/wrhp_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module wrhp_out_reg
  import wrhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = res_valid ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[sim/wav_parse_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_parse_check
// Watches both streams of the WAV/RIFF header parser. Every accepted input
// item runs through a local model of the parser; each result it causes is
// queued and compared with the next accepted result, field by field.
// ----------------------------------------------------------------------------
module wav_parse_check
  import wrhp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic [0:0]   in_tuser,   // [0] byte_valid
  input  logic         in_tlast,   // end_of_file
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] format_tag,
  // [42:27] channel_count, [74:43] rate_hz, [90:75] bits_per_sample,
  // [122:91] data_size, [127:123] zero
  input  logic [127:0] out_tdata,
  input  logic [1:0]   out_tuser,  // [0] payload_valid, [1] report_valid
  input  logic         out_tlast,  // payload_last
  output int           mismatches,
  output int           awaited
);

  // "RIFF", size (not checked), "WAVE"; byte 0 in the low bits
  localparam logic [95:0] RIFF_HEAD = {"EVAW", 32'h0, "FFIR"};

  phase_t      phase;
  logic [31:0] pos;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic        hdr_ok;
  logic        fmt_seen;
  logic        reported;
  logic [15:0] fmt_tag;
  logic [15:0] fmt_chan;
  logic [15:0] fmt_bits;
  logic [31:0] fmt_rate;

  result_t     payload_report_q[$];

  function automatic void clear_parser();
    phase    = PH_HEADER;
    pos      = '0;
    tag_acc  = '0;
    len_acc  = '0;
    hdr_ok   = 1'b1;
    fmt_seen = 1'b0;
    reported = 1'b0;
    fmt_tag  = '0;
    fmt_chan = '0;
    fmt_bits = '0;
    fmt_rate = '0;
  endfunction

  function automatic status_t data_verdict();
    if (!fmt_seen) return ST_NO_FMT;
    if (fmt_tag != PCM_TAG) return ST_NOT_PCM;
    return ST_OK;
  endfunction

  function automatic void issue_report(inout result_t r, input status_t st);
    r.report_valid = 1'b1;
    r.status       = st;
    if (st == ST_OK) begin
      r.format_tag      = fmt_tag;
      r.channel_count   = fmt_chan;
      r.rate_hz         = fmt_rate;
      r.bits_per_sample = fmt_bits;
      r.data_size       = len_acc;
    end
    reported = 1'b1;
    phase    = PH_DONE;
  endfunction

  // Advances the model by one item; returns 1 when the item causes a result.
  function automatic bit parser_step(input logic [7:0] b, input logic v, input logic e,
                                     output result_t r);
    bit      emit;
    status_t st;
    r    = '0;
    emit = 1'b0;
    if (v) begin
      case (phase)
        PH_HEADER: begin
          if ((pos < 4 || pos >= 8) && b != RIFF_HEAD[8*pos +: 8]) hdr_ok = 1'b0;
          pos = pos + 1;
          if (pos >= HDR_LEN) begin
            pos = '0;
            if (!hdr_ok) begin
              issue_report(r, ST_BAD_HDR);
              emit = 1'b1;
            end else begin
              phase = PH_CHUNK;
            end
          end
        end
        PH_CHUNK: begin
          if (pos < 4) tag_acc = {tag_acc[23:0], b};
          else len_acc = len_acc | ({24'h0, b} << (8 * (pos - 4)));
          pos = pos + 1;
          if (pos >= CHK_LEN) begin
            pos = '0;
            if (tag_acc == TAG_FMT) begin
              fmt_seen = 1'b1;
              fmt_tag  = '0;
              fmt_chan = '0;
              fmt_bits = '0;
              fmt_rate = '0;
              phase    = PH_FMT;
            end else if (tag_acc == TAG_DATA) begin
              if (len_acc == 0) begin
                issue_report(r, data_verdict());
                emit = 1'b1;
              end else begin
                phase = PH_DATA;
              end
            end else if (len_acc == 0) begin
              tag_acc = '0;
            end else begin
              phase = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          if (pos < 2) fmt_tag[8*pos[0] +: 8] = b;
          else if (pos < 4) fmt_chan[8*pos[0] +: 8] = b;
          else if (pos < 8) fmt_rate[8*pos[1:0] +: 8] = b;
          else if (pos == 14 || pos == 15) fmt_bits[8*pos[0] +: 8] = b;
          pos = pos + 1;
          if (pos >= FMT_CORE && pos >= len_acc) begin
            pos     = '0;
            tag_acc = '0;
            len_acc = '0;
            phase   = PH_CHUNK;
          end
        end
        PH_SKIP: begin
          pos = pos + 1;
          if (pos >= len_acc) begin
            pos     = '0;
            tag_acc = '0;
            len_acc = '0;
            phase   = PH_CHUNK;
          end
        end
        PH_DATA: begin
          r.payload_byte  = b;
          r.payload_valid = 1'b1;
          emit            = 1'b1;
          pos             = pos + 1;
          if (pos >= len_acc) begin
            r.payload_last = 1'b1;
            issue_report(r, data_verdict());
          end
        end
        default: begin
        end
      endcase
    end
    if (e) begin
      if (!reported) begin
        if (phase == PH_HEADER) st = ST_BAD_HDR;
        else if (phase == PH_DATA) st = ST_SHORT;
        else if (!fmt_seen) st = ST_NO_FMT;
        else st = ST_NO_DATA;
        issue_report(r, st);
        emit = 1'b1;
      end
      clear_parser();
    end
    return emit;
  endfunction

  function automatic void flag(input string what, input result_t x, input result_t a);
    mismatches = mismatches + 1;
    if (mismatches <= 10) begin
      $display("%0t %s", $realtime, what);
      $display("  expected pv=%0b byte=%02h last=%0b rv=%0b st=%0d tag=%04h ch=%04h",
               x.payload_valid, x.payload_byte, x.payload_last, x.report_valid,
               x.status, x.format_tag, x.channel_count);
      $display("           rate=%08h bits=%04h size=%08h",
               x.rate_hz, x.bits_per_sample, x.data_size);
      $display("  actual   pv=%0b byte=%02h last=%0b rv=%0b st=%0d tag=%04h ch=%04h",
               a.payload_valid, a.payload_byte, a.payload_last, a.report_valid,
               a.status, a.format_tag, a.channel_count);
      $display("           rate=%08h bits=%04h size=%08h pad=%02h",
               a.rate_hz, a.bits_per_sample, a.data_size, out_tdata[127:123]);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      clear_parser();
      payload_report_q.delete();
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (parser_step(in_tdata, in_tuser[0], in_tlast, want))
          payload_report_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.payload_byte    = out_tdata[7:0];
        got.payload_valid   = out_tuser[0];
        got.payload_last    = out_tlast;
        got.report_valid    = out_tuser[1];
        got.status          = out_tdata[10:8];
        got.format_tag      = out_tdata[26:11];
        got.channel_count   = out_tdata[42:27];
        got.rate_hz         = out_tdata[74:43];
        got.bits_per_sample = out_tdata[90:75];
        got.data_size       = out_tdata[122:91];
        if (payload_report_q.size() == 0) begin
          flag("result with nothing pending", '0, got);
        end else begin
          want = payload_report_q.pop_front();
          if (got.payload_valid   !== want.payload_valid   ||
              got.payload_byte    !== want.payload_byte    ||
              got.payload_last    !== want.payload_last    ||
              got.report_valid    !== want.report_valid    ||
              got.status          !== want.status          ||
              got.format_tag      !== want.format_tag      ||
              got.channel_count   !== want.channel_count   ||
              got.rate_hz         !== want.rate_hz         ||
              got.bits_per_sample !== want.bits_per_sample ||
              got.data_size       !== want.data_size       ||
              out_tdata[127:123]  !== 5'd0)
            flag("result mismatch", want, got);
        end
      end
    end
    awaited <= payload_report_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the WAV/RIFF header parser with whole files, byte by byte: a few
// hand-built files for the corner cases, then randomly assembled ones, mostly
// well-formed with random contents, some corrupted, truncated or pure noise.
// Both streams stall in random bursts; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  import wrhp_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int EOF_ON_BYTE = 0;   // end mark rides on the last file byte
  localparam int EOF_IDLE    = 1;   // end mark on an extra item with no byte
  localparam int EOF_EXTRA   = 2;   // end mark on an extra item with a byte

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [0:0]   in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  int           mismatches;
  int           awaited;
  int           cycles = 0;
  int           sent_bytes;
  int           hold_left = 0;
  bit           quiet;
  logic [7:0]   file_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wav_riff_header_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  wav_parse_check parse_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic v, input logic e);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= v;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (v) sent_bytes++;
  endtask

  // Sends the first upto bytes of the built file, then the end mark.
  task automatic ship(input int upto, input int end_mode);
    int i;
    for (i = 0; i < upto; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(file_bytes[i], 1'b1, end_mode == EOF_ON_BYTE && i == upto - 1);
    end
    if (end_mode != EOF_ON_BYTE) send_item(8'($urandom), end_mode == EOF_EXTRA, 1'b1);
    file_bytes.delete();
  endtask

  function automatic void push_header(input bit corrupt);
    logic [95:0] h;
    int          p;
    int          k;
    h = {"EVAW", 32'($urandom), "FFIR"};
    if (corrupt) begin
      p = $urandom_range(0, 7);
      if (p >= 4) p = p + 4;
      k = 8 * p + $urandom_range(0, 7);
      h[k] = ~h[k];
    end
    for (k = 0; k < 12; k++) file_bytes.push_back(h[8*k +: 8]);
  endfunction

  // Chunk header plus body; the first two body bytes come from lead.
  function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] len,
                                     input int body, input logic [15:0] lead);
    int k;
    for (k = 3; k >= 0; k--) file_bytes.push_back(tag[8*k +: 8]);
    for (k = 0; k < 4; k++) file_bytes.push_back(len[8*k +: 8]);
    for (k = 0; k < body; k++)
      file_bytes.push_back(k < 2 ? lead[8*k +: 8] : 8'($urandom));
  endfunction

  // Unknown chunk; a huge length ends the file part way through its body.
  function automatic void push_other(inout bit cut);
    logic [31:0] tag;
    int          n;
    tag = $urandom_range(0, 3) == 0 ? TAG_FMT ^ (32'h1 << $urandom_range(0, 31))
                                    : 32'($urandom);
    case ($urandom_range(0, 9))
      0:       push_chunk(tag, 32'd0, 0, 16'($urandom));
      1: begin
        push_chunk(tag, 32'($urandom), $urandom_range(0, 6), 16'($urandom));
        cut = 1'b1;
      end
      default: begin
        n = $urandom_range(1, 8);
        push_chunk(tag, n, n, 16'($urandom));
      end
    endcase
  endfunction

  task automatic random_file();
    int          r;
    int          n;
    int          k;
    bit          cut;
    logic [15:0] ftag;
    r   = $urandom_range(0, 99);
    cut = 1'b0;
    if (r < 8) begin
      n = $urandom_range(1, 30);
      for (k = 0; k < n; k++) file_bytes.push_back(8'($urandom));
      ship(n, $urandom_range(0, 2));
    end else begin
      push_header(r < 16);
      if ($urandom_range(0, 3) == 0) push_other(cut);
      if (!cut && $urandom_range(0, 9) != 0) begin
        ftag = $urandom_range(0, 4) == 0 ? 16'($urandom) : PCM_TAG;
        case ($urandom_range(0, 9))
          0: push_chunk(TAG_FMT, $urandom_range(0, 15), 16, ftag);
          1: begin
            n = $urandom_range(17, 24);
            push_chunk(TAG_FMT, n, n, ftag);
          end
          2: begin
            push_chunk(TAG_FMT, 32'($urandom), $urandom_range(0, 20), ftag);
            cut = 1'b1;
          end
          default: push_chunk(TAG_FMT, 32'd16, 16, ftag);
        endcase
      end
      if (!cut && $urandom_range(0, 4) == 0) push_other(cut);
      if (!cut && $urandom_range(0, 11) != 0) begin
        case ($urandom_range(0, 11))
          0: push_chunk(TAG_DATA, 32'd0, 0, 16'($urandom));
          1: begin
            n = $urandom_range(13, 64);
            push_chunk(TAG_DATA, n, n, 16'($urandom));
          end
          2: begin
            push_chunk(TAG_DATA, 32'($urandom), $urandom_range(0, 10), 16'($urandom));
            cut = 1'b1;
          end
          default: begin
            n = $urandom_range(1, 12);
            push_chunk(TAG_DATA, n, n, 16'($urandom));
          end
        endcase
        if (!cut) repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
      end
      n = file_bytes.size();
      if (!cut && $urandom_range(0, 9) == 0) n = $urandom_range(1, n);
      ship(n, $urandom_range(0, 2));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    quiet      = 1'b0;
    sent_bytes = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // end mark alone before any byte
    ship(0, EOF_IDLE);
    // bad header, then bytes that must be dropped
    push_header(1'b1);
    repeat (3) file_bytes.push_back(8'($urandom));
    ship(file_bytes.size(), EOF_ON_BYTE);
    // file ends inside the header
    push_header(1'b0);
    ship(5, EOF_ON_BYTE);
    // empty data chunk with no fmt chunk, junk after the report
    push_header(1'b0);
    push_chunk(TAG_DATA, 32'd0, 0, 16'h0000);
    repeat (2) file_bytes.push_back(8'hFF);
    ship(file_bytes.size(), EOF_EXTRA);
    // empty unknown chunk, long non-PCM fmt, skipped chunk, data
    push_header(1'b0);
    push_chunk(32'h4C495354, 32'd0, 0, 16'h0000);
    push_chunk(TAG_FMT, 32'd20, 20, 16'hFFFF);
    push_chunk(32'h6A756E6B, 32'd3, 3, 16'h0000);
    push_chunk(TAG_DATA, 32'd2, 2, 16'h00FF);
    ship(file_bytes.size(), EOF_ON_BYTE);
    // complete PCM file, end mark on an idle item
    push_header(1'b0);
    push_chunk(TAG_FMT, 32'd16, 16, PCM_TAG);
    push_chunk(TAG_DATA, 32'd3, 3, 16'hFF00);
    ship(file_bytes.size(), EOF_IDLE);
    // short fmt length, data body cut off
    push_header(1'b0);
    push_chunk(TAG_FMT, 32'd8, 16, PCM_TAG);
    push_chunk(TAG_DATA, 32'd10, 3, 16'h8001);
    ship(file_bytes.size(), EOF_ON_BYTE);
    // fmt but no data chunk
    push_header(1'b0);
    push_chunk(TAG_FMT, 32'd16, 16, PCM_TAG);
    ship(file_bytes.size(), EOF_EXTRA);
    // header only
    push_header(1'b0);
    ship(12, EOF_IDLE);
    // fmt body cut off
    push_header(1'b0);
    push_chunk(TAG_FMT, 32'd16, 9, PCM_TAG);
    ship(file_bytes.size(), EOF_ON_BYTE);

    while (sent_bytes < 1050) begin
      quiet = sent_bytes > 920;
      random_file();
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (awaited != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
